### rtl/core/bisection_root_finder_unit_defines.svh
// Assertion macros for the bisection root finder checker.
`ifndef BISECTION_ROOT_FINDER_UNIT_DEFINES_SVH
`define BISECTION_ROOT_FINDER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BRF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BRF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/brf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the bisection root finder.
package brf_pkg;

  localparam int VALUE_WIDTH = 28;
  localparam int FRAC_BITS   = 16;
  localparam int STOP_W      = 27;
  localparam int QUEUE_DEPTH = 2;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_STOP_WIDTH = '0;

  typedef enum logic [1:0] {
    FUNC_LINEAR = 2'd0,
    FUNC_SQUARE = 2'd1,
    FUNC_CUBE   = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    STATUS_FOUND     = 2'd0,
    STATUS_INVALID   = 2'd1,
    STATUS_NO_CHANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]                    func_select;
    logic signed [VALUE_WIDTH-1:0] lower_bound;
    logic signed [VALUE_WIDTH-1:0] upper_bound;
  } brf_in_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] root;
    logic [1:0]                    status;
  } brf_out_t;

  typedef struct packed {
    func_t                         func;
    logic                          invalid;
    logic signed [VALUE_WIDTH-1:0] lo;
    logic signed [VALUE_WIDTH-1:0] hi;
  } brf_job_t;

  typedef struct packed {
    logic zero;
    logic neg;
  } brf_sign_t;

  typedef struct packed {
    logic                          vld;
    func_t                         func;
    logic signed [VALUE_WIDTH-1:0] x;
  } brf_eval_req_t;

  typedef struct packed {
    logic      done;
    brf_sign_t sign;
  } brf_eval_rsp_t;

endpackage

### rtl/core/brf_front.sv
`timescale 1ns / 1ps
// Front end: takes requests, checks the interval and normalizes the selector.
module brf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  brf_pkg::brf_in_t  in_data,
  input  logic              q_full,
  output logic              q_push,
  output brf_pkg::brf_job_t q_wdata
);
  import brf_pkg::*;

  logic     stage_vld_r, stage_vld_nxt;
  brf_job_t stage_r, stage_nxt;
  logic     accept;

  assign q_push  = stage_vld_r && !q_full;
  assign busy    = stage_vld_r && q_full;
  assign accept  = start && !busy;
  assign q_wdata = stage_r;

  always_comb begin
    stage_nxt     = stage_r;
    stage_vld_nxt = stage_vld_r && !q_push;
    if (accept) begin
      stage_vld_nxt   = 1'b1;
      stage_nxt.lo    = in_data.lower_bound;
      stage_nxt.hi    = in_data.upper_bound;
      stage_nxt.invalid =
        ($signed(in_data.lower_bound) >= $signed(in_data.upper_bound));
      // selector 3 falls through to the cubic
      priority if (in_data.func_select == FUNC_LINEAR) begin
        stage_nxt.func = FUNC_LINEAR;
      end else if (in_data.func_select == FUNC_SQUARE) begin
        stage_nxt.func = FUNC_SQUARE;
      end else begin
        stage_nxt.func = FUNC_CUBE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_vld_r <= 1'b0;
    end else begin
      stage_vld_r <= stage_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stage_r <= stage_nxt;
  end

endmodule

### rtl/core/brf_queue.sv
`timescale 1ns / 1ps
// Short request queue between the front end and the solver.
module brf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  brf_pkg::brf_job_t wdata,
  input  logic              pop,
  output brf_pkg::brf_job_t rdata,
  output logic              empty,
  output logic              full
);
  import brf_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  brf_job_t         entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign rdata = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

### rtl/core/brf_poly_eval.sv
`timescale 1ns / 1ps
// Exact sign of the selected polynomial, with one multiplier shared between the steps.
module brf_poly_eval (
  input  logic                   clk,
  input  logic                   rst_n,
  input  brf_pkg::brf_eval_req_t req,
  output brf_pkg::brf_eval_rsp_t rsp
);
  import brf_pkg::*;

  localparam int VW = VALUE_WIDTH;
  localparam int LIN_W = ((VW + 1 > FRAC_BITS + 3) ? VW + 1 : FRAC_BITS + 3) + 1;
  localparam int SQ_CMP_W = (2 * VW + 1 > 2 * FRAC_BITS + 3) ?
                            2 * VW + 1 : 2 * FRAC_BITS + 3;
  localparam int CUBE_W = 3 * VW;
  localparam int CUBE_CMP_W = (3 * VW + 1 > 3 * FRAC_BITS + 6) ?
                              3 * VW + 1 : 3 * FRAC_BITS + 6;

  localparam logic signed [LIN_W-1:0] LIN_FIVE = LIN_W'(5) << FRAC_BITS;
  localparam logic [SQ_CMP_W-1:0] SQ_LIMIT = SQ_CMP_W'(3) << (2 * FRAC_BITS);
  localparam logic [CUBE_CMP_W-1:0] CUBE_LIMIT = CUBE_CMP_W'(30) << (3 * FRAC_BITS);

  typedef enum logic [6:0] {
    E_IDLE     = 7'b0000001,
    E_SQUARE   = 7'b0000010,
    E_SQ_CMP   = 7'b0000100,
    E_LO_PROD  = 7'b0001000,
    E_HI_PROD  = 7'b0010000,
    E_SUM      = 7'b0100000,
    E_CUBE_CMP = 7'b1000000
  } eval_state_t;

  eval_state_t         state_r, state_nxt;
  logic                done_r, done_nxt;
  brf_sign_t           sign_r, sign_nxt;
  func_t               func_r, func_nxt;
  logic [VW-1:0]       mag_r, mag_nxt;
  logic [2*VW-1:0]     sq_r, sq_nxt;
  logic [2*VW-1:0]     plo_r, plo_nxt;
  logic [2*VW-1:0]     phi_r, phi_nxt;
  logic [CUBE_W-1:0]   cube_r, cube_nxt;

  logic signed [LIN_W-1:0] x_ext;
  logic signed [LIN_W-1:0] lin;
  logic [VW-1:0]           mag;
  logic [VW-1:0]           mul_a, mul_b;
  logic [2*VW-1:0]         prod;
  logic [SQ_CMP_W-1:0]     sq_lhs;
  logic [CUBE_CMP_W-1:0]   cube_lhs;

  assign x_ext    = {{(LIN_W - VW){req.x[VW-1]}}, req.x};
  assign lin      = LIN_FIVE - (x_ext <<< 1);
  assign mag      = req.x[VW-1] ? VW'(~req.x + 1'b1) : VW'(req.x);
  assign prod     = (2 * VW)'(mul_a) * (2 * VW)'(mul_b);
  assign sq_lhs   = SQ_CMP_W'({sq_r, 1'b0});
  assign cube_lhs = CUBE_CMP_W'({cube_r, 1'b0});

  assign rsp.done = done_r;
  assign rsp.sign = sign_r;

  // one multiplier: square, then the two halves of square times magnitude
  always_comb begin
    mul_a = mag_r;
    mul_b = mag_r;
    if (state_r == E_LO_PROD) begin
      mul_a = sq_r[VW-1:0];
    end else if (state_r == E_HI_PROD) begin
      mul_a = sq_r[2*VW-1:VW];
    end
  end

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    sign_nxt  = sign_r;
    func_nxt  = func_r;
    mag_nxt   = mag_r;
    sq_nxt    = sq_r;
    plo_nxt   = plo_r;
    phi_nxt   = phi_r;
    cube_nxt  = cube_r;
    unique case (state_r)
      E_IDLE: begin
        if (req.vld) begin
          mag_nxt  = mag;
          func_nxt = req.func;
          if (req.func == FUNC_LINEAR) begin
            done_nxt      = 1'b1;
            sign_nxt.zero = (lin == '0);
            sign_nxt.neg  = (lin < 0);
          end else if (req.func == FUNC_CUBE && (req.x[VW-1] || req.x == '0)) begin
            // cubic is negative for any x <= 0
            done_nxt      = 1'b1;
            sign_nxt.zero = 1'b0;
            sign_nxt.neg  = 1'b1;
          end else begin
            state_nxt = E_SQUARE;
          end
        end
      end
      E_SQUARE: begin
        sq_nxt    = prod;
        state_nxt = (func_r == FUNC_SQUARE) ? E_SQ_CMP : E_LO_PROD;
      end
      E_SQ_CMP: begin
        done_nxt      = 1'b1;
        sign_nxt.zero = (sq_lhs == SQ_LIMIT);
        sign_nxt.neg  = (sq_lhs < SQ_LIMIT);
        state_nxt     = E_IDLE;
      end
      E_LO_PROD: begin
        plo_nxt   = prod;
        state_nxt = E_HI_PROD;
      end
      E_HI_PROD: begin
        phi_nxt   = prod;
        state_nxt = E_SUM;
      end
      E_SUM: begin
        cube_nxt  = {phi_r, VW'(0)} + CUBE_W'(plo_r);
        state_nxt = E_CUBE_CMP;
      end
      E_CUBE_CMP: begin
        done_nxt      = 1'b1;
        sign_nxt.zero = (cube_lhs == CUBE_LIMIT);
        sign_nxt.neg  = (cube_lhs < CUBE_LIMIT);
        state_nxt     = E_IDLE;
      end
      default: begin
        state_nxt = E_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sign_r <= sign_nxt;
    func_r <= func_nxt;
    mag_r  <= mag_nxt;
    sq_r   <= sq_nxt;
    plo_r  <= plo_nxt;
    phi_r  <= phi_nxt;
    cube_r <= cube_nxt;
  end

endmodule

### rtl/core/brf_back.sv
`timescale 1ns / 1ps
// Solver: endpoint sign check and the bisection loop, one request at a time.
module brf_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [brf_pkg::STOP_W-1:0] stop_width,
  input  logic                      q_empty,
  output logic                      q_pop,
  input  brf_pkg::brf_job_t         q_rdata,
  output brf_pkg::brf_eval_req_t    eval_req,
  input  brf_pkg::brf_eval_rsp_t    eval_rsp,
  output logic                      out_valid,
  output brf_pkg::brf_out_t         out_data
);
  import brf_pkg::*;

  localparam int VW    = VALUE_WIDTH;
  localparam int CMP_W = (VW > STOP_W) ? VW : STOP_W;

  typedef enum logic [6:0] {
    B_IDLE     = 7'b0000001,
    B_LO_REQ   = 7'b0000010,
    B_LO_WAIT  = 7'b0000100,
    B_HI_REQ   = 7'b0001000,
    B_HI_WAIT  = 7'b0010000,
    B_MID_REQ  = 7'b0100000,
    B_MID_WAIT = 7'b1000000
  } back_state_t;

  back_state_t             state_r, state_nxt;
  func_t                   func_r, func_nxt;
  logic signed [VW-1:0]    lo_r, lo_nxt;
  logic signed [VW-1:0]    hi_r, hi_nxt;
  logic signed [VW-1:0]    mid_r, mid_nxt;
  brf_sign_t               sa_r, sa_nxt;
  logic                    out_vld_r, out_vld_nxt;
  logic signed [VW-1:0]    root_r, root_nxt;
  logic [1:0]              status_r, status_nxt;

  logic [VW-1:0]           diff;
  logic signed [VW-1:0]    mid;
  logic [VW-1:0]           new_diff;
  logic                    more;

  assign diff = VW'(hi_r - lo_r);
  assign mid  = VW'(lo_r + $signed({1'b0, diff[VW-1:1]}));

  assign out_valid       = out_vld_r;
  assign out_data.root   = root_r;
  assign out_data.status = status_r;

  always_comb begin
    state_nxt   = state_r;
    func_nxt    = func_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    mid_nxt     = mid_r;
    sa_nxt      = sa_r;
    out_vld_nxt = 1'b0;
    root_nxt    = root_r;
    status_nxt  = status_r;
    q_pop       = 1'b0;
    new_diff    = diff;
    more        = 1'b0;
    eval_req.vld  = 1'b0;
    eval_req.func = func_r;
    eval_req.x    = lo_r;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          func_nxt = q_rdata.func;
          lo_nxt   = q_rdata.lo;
          hi_nxt   = q_rdata.hi;
          if (q_rdata.invalid) begin
            out_vld_nxt = 1'b1;
            root_nxt    = '0;
            status_nxt  = STATUS_INVALID;
          end else begin
            state_nxt = B_LO_REQ;
          end
        end
      end
      B_LO_REQ: begin
        eval_req.vld = 1'b1;
        eval_req.x   = lo_r;
        state_nxt    = B_LO_WAIT;
      end
      B_LO_WAIT: begin
        if (eval_rsp.done) begin
          sa_nxt    = eval_rsp.sign;
          state_nxt = B_HI_REQ;
        end
      end
      B_HI_REQ: begin
        eval_req.vld = 1'b1;
        eval_req.x   = hi_r;
        state_nxt    = B_HI_WAIT;
      end
      B_HI_WAIT: begin
        if (eval_rsp.done) begin
          if (sa_r.zero || eval_rsp.sign.zero || (sa_r.neg == eval_rsp.sign.neg)) begin
            out_vld_nxt = 1'b1;
            root_nxt    = '0;
            status_nxt  = STATUS_NO_CHANGE;
            state_nxt   = B_IDLE;
          end else begin
            state_nxt = B_MID_REQ;
          end
        end
      end
      B_MID_REQ: begin
        eval_req.vld = 1'b1;
        eval_req.x   = mid;
        mid_nxt      = mid;
        state_nxt    = B_MID_WAIT;
      end
      B_MID_WAIT: begin
        if (eval_rsp.done) begin
          if (eval_rsp.sign.neg != sa_r.neg) begin
            hi_nxt = mid_r;
          end else begin
            lo_nxt = mid_r;
          end
          new_diff = VW'(hi_nxt - lo_nxt);
          more = (CMP_W'(new_diff) > CMP_W'(stop_width)) && (new_diff > VW'(1));
          // exact zero at the midpoint ends the search
          if (eval_rsp.sign.zero || !more) begin
            out_vld_nxt = 1'b1;
            root_nxt    = mid_r;
            status_nxt  = STATUS_FOUND;
            state_nxt   = B_IDLE;
          end else begin
            state_nxt = B_MID_REQ;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r   <= func_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    mid_r    <= mid_nxt;
    sa_r     <= sa_nxt;
    root_r   <= root_nxt;
    status_r <= status_nxt;
  end

endmodule

### rtl/core/bisection_root_finder_unit.sv
`timescale 1ns / 1ps
// Each solve checks both endpoint signs, then up to 28 halvings, each with one polynomial sign.
// The linear case and cubic at x <= 0 need no product, the square needs one, the cubic three:
// one shared 28x28 multiplier takes one product per cycle. Invalid intervals skip the evaluation.
// The solver takes one request per solve; front stage plus two-entry queue hold three more.
// Synchronous active-low reset clears control state and stop_width; no result pending.
// Top level: APB register, front end, request queue, solver and polynomial unit.
module bisection_root_finder_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  brf_pkg::brf_in_t               in_data,
  output logic                           out_valid,
  output brf_pkg::brf_out_t              out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [brf_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [brf_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [brf_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import brf_pkg::*;

  logic [STOP_W-1:0] stop_width_r;
  logic              stop_sel;

  logic          q_push, q_pop, q_empty, q_full;
  brf_job_t      q_wdata, q_rdata;
  brf_eval_req_t eval_req;
  brf_eval_rsp_t eval_rsp;

  assign pready   = 1'b1;
  assign stop_sel = (paddr[CFG_ADDR_W-1:2] == REG_STOP_WIDTH);
  assign prdata   = stop_sel ? CFG_DATA_W'(stop_width_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_width_r <= '0;
    end else if (psel && penable && pwrite && pready && stop_sel) begin
      stop_width_r <= pwdata[STOP_W-1:0];
    end
  end

  brf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_data (in_data),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_wdata (q_wdata)
  );

  brf_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .full  (q_full)
  );

  brf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .stop_width (stop_width_r),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .q_rdata    (q_rdata),
    .eval_req   (eval_req),
    .eval_rsp   (eval_rsp),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

  brf_poly_eval u_poly_eval (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (eval_req),
    .rsp   (eval_rsp)
  );

endmodule

### rtl/core/brf_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the bisection root finder, bound to the top level.
`include "bisection_root_finder_unit_defines.svh"

module brf_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic                           out_valid,
  input brf_pkg::brf_out_t              out_data,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [brf_pkg::CFG_ADDR_W-1:0] paddr,
  input logic [brf_pkg::CFG_DATA_W-1:0] pwdata,
  input logic [brf_pkg::CFG_DATA_W-1:0] prdata,
  input logic                           pready
);
  import brf_pkg::*;

  logic                  failed;
  logic                  cfg_wr0;
  logic [CFG_DATA_W-1:0] wr_val;

  assign failed  = out_valid && (out_data.status != STATUS_FOUND);
  assign cfg_wr0 = psel && penable && pwrite && pready && (paddr == '0);
  assign wr_val  = CFG_DATA_W'(pwdata[STOP_W-1:0]);

  `BRF_ASSERT_IMP(a_status_legal, out_valid, out_data.status <= STATUS_NO_CHANGE, "bad status")

  `BRF_ASSERT_IMP(a_root_zero, failed, out_data.root == '0, "nonzero root on a failed request")

  // busy only rises after a request was taken
  `BRF_ASSERT_NEXT(a_busy_needs_request, !start && !busy, !busy, "busy with no request")

  `BRF_ASSERT_IMP(a_cfg_readback, cfg_wr0 ##1 (paddr == '0), prdata == $past(wr_val), "bad readback")

endmodule

bind bisection_root_finder_unit brf_checker u_brf_checker (.*);
